// File: hdl/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int KEY_W = 32;
  localparam int ACT_W = 2;
  localparam int COUNT_W = 7;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic signed [KEY_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] top_value;
    logic [COUNT_W-1:0] entry_count;
    logic is_empty;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    cell_op_t op;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic ge;
    logic signed [KEY_W-1:0] key;
  } cell_link_t;

endpackage

`default_nettype wire

// File: hdl/bmhq_cell.sv
`default_nettype none

module bmhq_cell
  import bmhq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_cmd_t  cmd,
  input  wire cell_link_t prev,
  input  wire cell_link_t next,
  output cell_link_t      link
);

  logic                    valid;
  logic                    valid_next;
  logic signed [KEY_W-1:0] value;
  logic signed [KEY_W-1:0] value_next;
  logic                    own_ge;

  // occupied and not smaller than the key on the broadcast
  assign own_ge = valid && ($signed(value) >= $signed(cmd.key));

  always_comb begin
    valid_next = valid;
    value_next = value;
    case (cmd.op)
      OP_PUSH: begin
        if (!own_ge) begin
          if (prev.ge) begin
            valid_next = 1'b1;
            value_next = cmd.key;
          end else begin
            valid_next = prev.valid;
            value_next = prev.key;
          end
        end
      end
      OP_POP: begin
        valid_next = next.valid;
        value_next = next.key;
      end
      OP_CLEAR: begin
        valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
  end

  assign link.valid = valid;
  assign link.ge = own_ge;
  assign link.key = value;

endmodule

`default_nettype wire

// File: hdl/binary_max_heap_queue.sv
// result: registered, valid in the cycle after its request transaction is accepted
// throughput: one transaction per cycle while responses are taken, set by the single
//   compare in each cell of the sorted chain against the broadcast key
// reset: clears the response valid, the entry count and every cell's occupancy bit;
//   cell keys are not reset
`default_nettype none

module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam cell_link_t HEAD = '{valid: 1'b1, ge: 1'b1, key: '0};
  localparam cell_link_t TAIL = '{valid: 1'b0, ge: 1'b0, key: '0};

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] status;
  logic [STAT_W-1:0] status_next;
  logic              accept;
  cell_cmd_t         cmd;
  cell_link_t        links [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept = req_valid && req_ready;

  always_comb begin
    cmd.op = OP_HOLD;
    cmd.key = req.value;
    count_next = count;
    status_next = ST_OK;
    if (accept) begin
      case (req.action)
        ACT_PUSH: begin
          if (count == CNT_W'(CAPACITY)) begin
            status_next = ST_PUSH_FULL;
          end else begin
            cmd.op = OP_PUSH;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_POP: begin
          if (count == '0) begin
            status_next = ST_POP_EMPTY;
          end else begin
            cmd.op = OP_POP;
            count_next = count - CNT_W'(1);
          end
        end
        ACT_CLEAR: begin
          cmd.op = OP_CLEAR;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // sorted chain, largest key in cell zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t prev_link;
    cell_link_t next_link;
    if (i == 0) begin : g_head
      assign prev_link = HEAD;
    end else begin : g_mid
      assign prev_link = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_link = TAIL;
    end else begin : g_body
      assign next_link = links[i+1];
    end
    bmhq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .prev (prev_link),
      .next (next_link),
      .link (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      count <= '0;
      status <= ST_OK;
    end else begin
      if (accept) begin
        rsp_valid <= 1'b1;
        count <= count_next;
        status <= status_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.top_value = links[0].valid ? links[0].key : '0;
  assign rsp.entry_count = COUNT_W'(count);
  assign rsp.is_empty = (count == '0);
  assign rsp.status = status;

endmodule

`default_nettype wire

// File: tb/binary_max_heap_queue_tb.sv
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int ITEMS = 1750;
  localparam int SLACK_CYCLES = 20;
  localparam int LONG_HOLD = 400;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic drain;
    req_t req;
  } pend_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  pend_item_t stim_q[$];
  rsp_t report_due_q[$];
  int total_items = 1;
  int n_sent = 0;
  int n_recv = 0;
  int errors = 0;
  int hold_left = 0;
  int next_hold = 250;

  // predictor copy of the heap
  logic signed [KEY_W-1:0] heap_keys [DEFAULT_CAPACITY];
  int fill = 0;

  binary_max_heap_queue #(
    .CAPACITY(DEFAULT_CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t heap_step(req_t r);
    rsp_t o;
    int i;
    int p;
    int l;
    int rt;
    int b;
    logic signed [KEY_W-1:0] t;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_PUSH: begin
        if (fill >= DEFAULT_CAPACITY) begin
          o.status = ST_PUSH_FULL;
        end else begin
          heap_keys[fill] = r.value;
          fill++;
          i = fill - 1;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_keys[i] <= heap_keys[p]) break;
            t = heap_keys[i];
            heap_keys[i] = heap_keys[p];
            heap_keys[p] = t;
            i = p;
          end
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          o.status = ST_POP_EMPTY;
        end else begin
          heap_keys[0] = heap_keys[fill-1];
          fill--;
          i = 0;
          while (1'b1) begin
            l = 2 * i + 1;
            rt = 2 * i + 2;
            b = i;
            if (l < fill && heap_keys[l] > heap_keys[b]) b = l;
            if (rt < fill && heap_keys[rt] > heap_keys[b]) b = rt;
            if (b == i) break;
            t = heap_keys[i];
            heap_keys[i] = heap_keys[b];
            heap_keys[b] = t;
            i = b;
          end
        end
      end
      ACT_CLEAR: begin
        fill = 0;
      end
      default: begin
      end
    endcase
    o.top_value = (fill > 0) ? heap_keys[0] : '0;
    o.entry_count = COUNT_W'(fill);
    o.is_empty = (fill == 0);
    return o;
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [ACT_W-1:0] a, logic signed [KEY_W-1:0] v);
    pend_item_t e;
    e.req.action = a;
    e.req.value = v;
    e.drain = (stim_q.size() > 0 && stim_q.size() % 300 == 0);
    stim_q.insert(stim_q.size(), e);
  endtask

  // driver
  always @(posedge clk) begin : drive
    bit fire;
    bit got;
    bit idle;
    int pct;
    pend_item_t p;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      fire = req_valid && req_ready;
      got = rsp_valid && rsp_ready;
      if (fire) begin
        report_due_q.insert(report_due_q.size(), heap_step(req));
        n_sent <= n_sent + 1;
      end
      if (!req_valid || req_ready) begin
        case ((n_sent * 3) / total_items)
          0: pct = 38;
          1: pct = 61;
          default: pct = 0;
        endcase
        idle = stim_q.size() == 0 || ($urandom_range(99) < pct) ||
               (stim_q[0].drain && (n_sent + fire != n_recv + got));
        if (idle) begin
          req_valid <= 1'b0;
        end else begin
          p = stim_q.pop_front();
          req <= p.req;
          req_valid <= 1'b1;
        end
      end
    end
  end

  // receiver ready, with long hold-offs to back the block up
  always @(posedge clk) begin : sink
    int pct;
    case ((n_sent * 3) / total_items)
      0: pct = 61;
      1: pct = 38;
      default: pct = 0;
    endcase
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (n_recv >= next_hold) begin
      hold_left = LONG_HOLD;
      next_hold = next_hold + 1050;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= pct);
    end
  end

  // monitor
  always @(posedge clk) begin : check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      n_recv <= n_recv + 1;
      if (report_due_q.size() == 0) begin
        $error("unexpected transaction: top_value %0d entry_count %0d", rsp.top_value,
               rsp.entry_count);
        errors++;
      end else begin
        want = report_due_q.pop_front();
        if (rsp.top_value !== want.top_value) begin
          $error("top_value: expected %0d, actual %0d", want.top_value, rsp.top_value);
          errors++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 rsp.entry_count);
          errors++;
        end
        if (rsp.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp.is_empty);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          errors++;
        end
      end
    end
  end

  initial begin
    int kind;
    int n;
    int r;
    // directed: extremes, empty and no-op actions, ties
    add_item(ACT_PUSH, 32'sh7fffffff);
    add_item(ACT_PUSH, 32'sh80000000);
    add_item(ACT_PUSH, 0);
    add_item(ACT_PUSH, -1);
    repeat (4) add_item(ACT_POP, $urandom);
    add_item(ACT_POP, $urandom);
    add_item(ACT_CLEAR, $urandom);
    add_item(ACT_UNUSED, $urandom);
    add_item(ACT_PUSH, 5);
    add_item(ACT_PUSH, 5);
    add_item(ACT_PUSH, 5);
    add_item(ACT_PUSH, 7);
    add_item(ACT_POP, $urandom);
    add_item(ACT_POP, $urandom);
    add_item(ACT_PUSH, 3);
    add_item(ACT_PUSH, 9);
    add_item(ACT_PUSH, 9);
    add_item(ACT_POP, $urandom);
    add_item(ACT_UNUSED, $urandom);
    add_item(ACT_CLEAR, $urandom);
    add_item(ACT_POP, $urandom);
    // fill past capacity, then drain past empty
    repeat (DEFAULT_CAPACITY + 3) add_item(ACT_PUSH, rand_key());
    repeat (DEFAULT_CAPACITY + 3) add_item(ACT_POP, $urandom);
    while (stim_q.size() < ITEMS) begin
      kind = $urandom_range(9);
      n = $urandom_range(24, 4);
      case (kind)
        0, 1, 2, 3: begin
          repeat (n) begin
            r = $urandom_range(99);
            if (r < 52) add_item(ACT_PUSH, rand_key());
            else if (r < 90) add_item(ACT_POP, $urandom);
            else if (r < 96) add_item(ACT_CLEAR, $urandom);
            else add_item(ACT_UNUSED, $urandom);
          end
        end
        4, 5: repeat (n * 3) add_item(ACT_PUSH, rand_key());
        6, 7: repeat (n * 2) add_item(ACT_POP, $urandom);
        8: begin
          add_item(ACT_CLEAR, $urandom);
          repeat (n) add_item(ACT_PUSH, rand_key());
        end
        default: begin
          repeat (n) begin
            if ($urandom_range(99) < 60) add_item(ACT_PUSH, $urandom_range(2));
            else add_item(ACT_POP, $urandom);
          end
        end
      endcase
    end
    total_items = stim_q.size();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (stim_q.size() != 0 || req_valid || report_due_q.size() != 0);
    repeat (SLACK_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/bmhq_pkg.sv
hdl/bmhq_cell.sv
hdl/binary_max_heap_queue.sv
tb/binary_max_heap_queue_tb.sv
